// ----- hdl/hpack_huffman_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// hpack_huffman_decoder_macros
// Assertion macros used by the decoder datapath. Clock clk, reset arst_n.
// ----------------------------------------------------------------------------
`ifndef HPACK_HUFFMAN_DECODER_MACROS_SVH
`define HPACK_HUFFMAN_DECODER_MACROS_SVH

// same-cycle implication
`define HHD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HHD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/hhd_pkg.sv -----
// ----------------------------------------------------------------------------
// hhd_pkg
// Types, result codes and canonical code tables of the HPACK Huffman decoder.
// ----------------------------------------------------------------------------
package hhd_pkg;

	localparam int NUM_SYMS = 257;
	localparam int MAX_LEN  = 30;
	localparam int SYM_W    = 9;

	// result kinds
	localparam logic [1:0] KIND_SYM = 2'd0;
	localparam logic [1:0] KIND_END = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	localparam logic [4:0] MAX_PAD  = 5'd7;
	localparam logic [4:0] LEN_LAST = 5'(MAX_LEN);

	// code length per symbol, RFC 7541 appendix B (symbol 256 is EOS)
	localparam logic [4:0] HP_LEN [NUM_SYMS] = '{
		13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
		28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
		6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
		5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
		13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
		7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
		15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
		6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
		20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
		24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
		22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
		21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
		26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
		19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
		20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
		26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26,
		30
	};

	typedef logic [MAX_LEN:0][MAX_LEN-1:0] first_tab_t;
	typedef logic [MAX_LEN:0][SYM_W-1:0]   cnt_tab_t;
	typedef logic [NUM_SYMS-1:0][SYM_W-1:0] sym_tab_t;

	// codes per length
	function automatic cnt_tab_t calc_count();
		cnt_tab_t t;
		t = '0;
		for (int s = 0; s < NUM_SYMS; s++) begin
			t[HP_LEN[s]] = t[HP_LEN[s]] + SYM_W'(1);
		end
		return t;
	endfunction

	// first canonical code of each length
	function automatic first_tab_t calc_first();
		cnt_tab_t   c;
		first_tab_t t;
		logic [MAX_LEN:0] code;
		c    = calc_count();
		t    = '0;
		code = '0;
		for (int l = 1; l <= MAX_LEN; l++) begin
			t[l] = code[MAX_LEN-1:0];
			code = (code + {{(MAX_LEN+1-SYM_W){1'b0}}, c[l]}) << 1;
		end
		return t;
	endfunction

	// position of the first symbol of each length in the sorted list
	function automatic cnt_tab_t calc_offset();
		cnt_tab_t c;
		cnt_tab_t t;
		logic [SYM_W-1:0] acc;
		c   = calc_count();
		t   = '0;
		acc = '0;
		for (int l = 1; l <= MAX_LEN; l++) begin
			t[l] = acc;
			acc  = acc + c[l];
		end
		return t;
	endfunction

	// symbols sorted by code length, then by value
	function automatic sym_tab_t calc_sorted();
		sym_tab_t t;
		int n;
		t = '0;
		n = 0;
		for (int l = 1; l <= MAX_LEN; l++) begin
			for (int s = 0; s < NUM_SYMS; s++) begin
				if (HP_LEN[s] == 5'(l)) begin
					t[n] = SYM_W'(s);
					n++;
				end
			end
		end
		return t;
	endfunction

	localparam first_tab_t FIRST_CODE = calc_first();
	localparam cnt_tab_t   CODE_COUNT = calc_count();
	localparam cnt_tab_t   SYM_OFFSET = calc_offset();
	localparam sym_tab_t   SORTED_SYM = calc_sorted();

	// EOS has the longest code length and is the highest symbol: last in the sorted list
	localparam logic [SYM_W-1:0] EOS_IDX = SYM_W'(NUM_SYMS - 1);

	typedef struct packed {
		logic load;    // take a new byte
		logic step;    // decode one bit
		logic finish;  // end-of-string padding check
		logic flush;   // send held result as last of run
	} hhd_cmd_t;

	typedef struct packed {
		logic drop;      // dropping after an error
		logic eos;       // current byte ends the string
		logic bit_last;  // current bit is bit 0
		logic step_err;  // current bit hits EOS or a missing code
		logic hold_vld;  // a result waits in the hold register
		logic out_free;  // output register can take a result
	} hhd_stat_t;

endpackage

// ----- hdl/hhd_ctrl.sv -----
// ----------------------------------------------------------------------------
// hhd_ctrl
// Sequencer: byte accept, bit steps (eight, fewer on error), end-of-string check, flush.
// ----------------------------------------------------------------------------
module hhd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             code_valid,
	output logic             code_ready,
	input  hhd_pkg::hhd_stat_t st,
	output hhd_pkg::hhd_cmd_t  cmd
);
	import hhd_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_STEP   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;
	localparam logic [1:0] S_FLUSH  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       go;

	// a new result may displace the held one only if the output can take it
	assign go = !st.hold_vld || st.out_free;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		code_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				code_ready = 1'b1;
				if (code_valid) begin
					cmd.load = 1'b1;
					if (!st.drop) begin
						state_d = S_STEP;
					end
				end
			end
			S_STEP: begin
				if (go) begin
					cmd.step = 1'b1;
					if (st.step_err) begin
						state_d = S_FLUSH;
					end else if (st.bit_last) begin
						state_d = st.eos ? S_FINISH : S_FLUSH;
					end
				end
			end
			S_FINISH: begin
				if (go) begin
					cmd.finish = 1'b1;
					state_d    = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (!st.hold_vld) begin
					state_d = S_IDLE;
				end else if (st.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/hhd_datapath.sv -----
// ----------------------------------------------------------------------------
// hhd_datapath
// Canonical-code bit walker, hold register and output register.
// ----------------------------------------------------------------------------
`include "hpack_huffman_decoder_macros.svh"

module hhd_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  hhd_pkg::hhd_cmd_t  cmd,
	output hhd_pkg::hhd_stat_t st,
	input  logic [7:0]         code_byte,
	input  logic               end_of_string,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [1:0]         result_kind,
	output logic [7:0]         symbol,
	output logic               last_of_run
);
	import hhd_pkg::*;

	// byte and walk state
	logic [7:0]           byte_q;
	logic                 eos_q;
	logic [2:0]           bit_q;
	logic [MAX_LEN-2:0]   code_q;
	logic [4:0]           len_q;
	logic                 ones_q;
	logic                 drop_q;
	// hold and output registers
	logic                 hold_vld_q;
	logic [1:0]           hold_kind_q;
	logic [SYM_W-1:0]     hold_idx_q;
	logic                 out_valid_q;
	logic [1:0]           kind_q;
	logic [7:0]           symbol_q;
	logic                 last_q;

	logic                 cur_bit;
	logic [MAX_LEN-1:0]   ncode;
	logic [4:0]           nlen;
	logic [MAX_LEN-1:0]   diff;
	logic                 hit;
	logic [SYM_W-1:0]     idx;
	logic                 step_eos;
	logic                 step_miss;
	logic                 step_err;
	logic                 step_sym;
	logic                 step_res;
	logic                 pad_ok;
	logic                 out_free;
	logic                 push;
	logic                 push_last;

	// one bit of the walk: code value within its length range is a leaf
	assign cur_bit   = byte_q[bit_q];
	assign ncode     = {code_q, cur_bit};
	assign nlen      = len_q + 5'd1;
	assign diff      = ncode - FIRST_CODE[nlen];
	assign hit       = diff < {{(MAX_LEN-SYM_W){1'b0}}, CODE_COUNT[nlen]};
	assign idx       = SYM_OFFSET[nlen] + diff[SYM_W-1:0];
	assign step_eos  = hit && (idx == EOS_IDX);
	assign step_miss = !hit && (nlen == LEN_LAST);
	assign step_err  = step_eos || step_miss;
	assign step_sym  = hit && !step_eos;
	assign step_res  = step_err || step_sym;

	assign pad_ok    = (len_q == 5'd0) || ((len_q <= MAX_PAD) && ones_q);
	assign out_free  = !out_valid_q || result_ready;

	// held result moves to output when displaced or on flush
	assign push      = hold_vld_q && ((cmd.step && step_res) || cmd.finish || cmd.flush);
	assign push_last = cmd.flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q       <= '0;
			code_q      <= '0;
			len_q       <= '0;
			ones_q      <= 1'b1;
			drop_q      <= 1'b0;
			hold_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				bit_q <= 3'd7;
				if (drop_q && end_of_string) begin
					drop_q <= 1'b0;
				end
			end
			if (cmd.step) begin
				bit_q <= bit_q - 3'd1;
				if (step_res) begin
					code_q     <= '0;
					len_q      <= '0;
					ones_q     <= 1'b1;
					hold_vld_q <= 1'b1;
				end else begin
					code_q <= ncode[MAX_LEN-2:0];
					len_q  <= nlen;
					ones_q <= ones_q && cur_bit;
				end
				if (step_err && !eos_q) begin
					drop_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				code_q     <= '0;
				len_q      <= '0;
				ones_q     <= 1'b1;
				hold_vld_q <= 1'b1;
			end
			if (cmd.flush) begin
				hold_vld_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= code_byte;
			eos_q  <= end_of_string;
		end
		if (cmd.step && step_res) begin
			hold_kind_q <= step_err ? KIND_ERR : KIND_SYM;
			hold_idx_q  <= idx;
		end
		if (cmd.finish) begin
			hold_kind_q <= pad_ok ? KIND_END : KIND_ERR;
			hold_idx_q  <= '0;
		end
		if (push) begin
			kind_q   <= hold_kind_q;
			// registered read of the sorted-symbol ROM
			symbol_q <= (hold_kind_q == KIND_SYM) ? SORTED_SYM[hold_idx_q][7:0] : 8'd0;
			last_q   <= push_last;
		end
	end

	assign st.drop     = drop_q;
	assign st.eos      = eos_q;
	assign st.bit_last = (bit_q == 3'd0);
	assign st.step_err = step_err;
	assign st.hold_vld = hold_vld_q;
	assign st.out_free = out_free;

	assign result_valid = out_valid_q;
	assign result_kind  = kind_q;
	assign symbol       = symbol_q;
	assign last_of_run  = last_q;

	`HHD_ASSERT_IMP(a_push_free, push, out_free, "result pushed into a busy output register")
	`HHD_ASSERT_NXT(a_hold_set, cmd.step && step_res, hold_vld_q, "step result not held")
	`HHD_ASSERT_IMP(a_drop_root, drop_q, (len_q == 5'd0) && (code_q == '0), "walk not at root while dropping")
	`HHD_ASSERT_IMP(a_len_range, 1'b1, len_q < LEN_LAST, "pending code deeper than longest code")

endmodule

// ----- hdl/hpack_huffman_decoder.sv -----
// ----------------------------------------------------------------------------
// hpack_huffman_decoder
// HPACK string Huffman decoder using the RFC 7541 static code.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel code_valid/code_ready carries one coded byte per transfer
//    (code_byte, MSB first) with end_of_string on the last byte of a string.
//  - Output channel result_valid/result_ready gives up to three results per
//    byte: decoded symbols, then a string-end or error result; last_of_run
//    flags the final result of each byte. A byte that only extends a pending
//    code gives no result.
//  - Each byte passes an accept state, each of its eight bits in turn (one
//    canonical-code compare per bit), a padding check on end_of_string and a
//    flush state; the next byte is accepted only after the flush. An error ends
//    the byte at the failing bit. Bytes dropped after an error are only accepted.
//  - A result waits in the hold register until the next result of its byte or
//    the end of the byte, and only then moves to the output register.
//  - A held result plus the output register decouple the sides; when the
//    receiver stalls and both are full, decoding pauses at the next bit and
//    resumes on ready. The next byte is accepted while the final result waits.
//  - Reset puts the walk at the root with no pending bits and clears the
//    drop flag and both result slots. The code tables are constants.
// ----------------------------------------------------------------------------
module hpack_huffman_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       code_valid,
	output logic       code_ready,
	input  logic [7:0] code_byte,
	input  logic       end_of_string,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [1:0] result_kind,
	output logic [7:0] symbol,
	output logic       last_of_run
);
	import hhd_pkg::*;

	hhd_cmd_t  cmd;  // sequencer commands to the walker
	hhd_stat_t st;   // walker status back to the sequencer

	hhd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.st         (st),
		.cmd        (cmd)
	);

	hhd_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.code_byte     (code_byte),
		.end_of_string (end_of_string),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result_kind   (result_kind),
		.symbol        (symbol),
		.last_of_run   (last_of_run)
	);

endmodule
